### hdl/stok_pkg.sv
`default_nettype none
package stok_pkg;

  localparam int unsigned PositionBitsDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic       kind;
    logic [5:0] cls;
    logic [7:0] ch;
    logic [15:0] line;
    logic [15:0] col;
  } rec_t;

  typedef struct packed {
    logic [1:0]     cnt;
    rec_t [2:0]     rec;
  } bundle_t;

  localparam logic [5:0] ClsError  = 6'd0;
  localparam logic [5:0] ClsEof    = 6'd1;
  localparam logic [5:0] ClsIdent  = 6'd2;
  localparam logic [5:0] ClsAtom   = 6'd3;
  localparam logic [5:0] ClsNumber = 6'd4;
  localparam logic [5:0] ClsString = 6'd5;

  localparam logic KindContent = 1'b0;
  localparam logic KindEnd     = 1'b1;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_ident_start(input logic [7:0] b);
    return is_alpha(b) || b >= 8'hC0;
  endfunction

  function automatic logic is_name(input logic [7:0] b);
    return is_alpha(b) || b >= 8'h80 || is_digit(b) || b == 8'h5F;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_e(input logic [7:0] b);
    return b == 8'h65 || b == 8'h45;
  endfunction

  function automatic logic is_sign(input logic [7:0] b);
    return b == 8'h2B || b == 8'h2D;
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] p);
    case (p)
      8'h2B: return 6'd16;
      8'h2D: return 6'd17;
      8'h21: return 6'd25;
      8'h3C: return 6'd28;
      8'h3E: return 6'd29;
      8'h3D: return 6'd15;
      8'h26: return 6'd22;
      8'h7C: return 6'd23;
      default: return ClsError;
    endcase
  endfunction

  function automatic logic [5:0] op_double(input logic [7:0] p);
    case (p)
      8'h2B: return 6'd33;
      8'h2D: return 6'd32;
      8'h21: return 6'd27;
      8'h3C: return 6'd30;
      8'h3E: return 6'd31;
      8'h3D: return 6'd26;
      8'h26: return 6'd21;
      8'h7C: return 6'd24;
      default: return ClsError;
    endcase
  endfunction

  function automatic logic [7:0] op_second(input logic [7:0] p);
    if (p == 8'h2B || p == 8'h2D || p == 8'h26 || p == 8'h7C) return p;
    return 8'h3D;
  endfunction

  function automatic logic [5:0] single_char(input logic [7:0] b);
    case (b)
      8'h28: return 6'd6;
      8'h29: return 6'd7;
      8'h7B: return 6'd8;
      8'h7D: return 6'd9;
      8'h5B: return 6'd10;
      8'h5D: return 6'd11;
      8'h2C: return 6'd12;
      8'h3B: return 6'd13;
      8'h2E: return 6'd14;
      8'h2A: return 6'd18;
      8'h2F: return 6'd19;
      8'h25: return 6'd20;
      default: return ClsError;
    endcase
  endfunction

  // Keyword match on the saved name bytes; longer names never match.
  function automatic logic [5:0] ident_class(input logic [39:0] pre, input logic [2:0] len);
    if (len == 3'd3 && pre == 40'h0000766172) return 6'd34;
    if (len == 3'd3 && pre == 40'h000066756E) return 6'd35;
    if (len == 3'd2 && pre == 40'h000000666E) return 6'd36;
    if (len == 3'd4 && pre == 40'h0073616D65) return 6'd37;
    if (len == 3'd2 && pre == 40'h0000006966) return 6'd38;
    if (len == 3'd4 && pre == 40'h00656C6966) return 6'd39;
    if (len == 3'd4 && pre == 40'h00656C7365) return 6'd40;
    if (len == 3'd5 && pre == 40'h7768696C65) return 6'd41;
    return ClsIdent;
  endfunction

endpackage
`default_nettype wire

### hdl/stok_if.sv
`default_nettype none
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;
  modport source (output valid, output byte_in, output end_of_input, input ready);
  modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [5:0]  token_class;
  logic [7:0]  char_value;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last;
  modport source (output valid, output record_kind, output token_class, output char_value,
                  output line_number, output column_number, output last, input ready);
  modport sink (input valid, input record_kind, input token_class, input char_value,
                input line_number, input column_number, input last, output ready);
endinterface
`default_nettype wire

### hdl/stok_front.sv
`default_nettype none
module stok_front #(
  parameter int unsigned POSITION_BITS = stok_pkg::PositionBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              eoi_i,
  output stok_pkg::bundle_t      bundle_o
);

  localparam logic [3:0] ModeIdle    = 4'd0;
  localparam logic [3:0] ModeComment = 4'd1;
  localparam logic [3:0] ModeIdent   = 4'd2;
  localparam logic [3:0] ModeAtom0   = 4'd3;
  localparam logic [3:0] ModeAtom    = 4'd4;
  localparam logic [3:0] ModeStr     = 4'd5;
  localparam logic [3:0] ModeEsc     = 4'd6;
  localparam logic [3:0] ModeOp      = 4'd7;
  localparam logic [3:0] ModeInt     = 4'd8;
  localparam logic [3:0] ModeDots    = 4'd9;
  localparam logic [3:0] ModeFrac    = 4'd10;
  localparam logic [3:0] ModeExp     = 4'd11;
  localparam logic [3:0] ModeSign    = 4'd12;
  localparam logic [3:0] ModeExpd    = 4'd13;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

  logic [3:0]               mode_q, mode_d;
  logic [7:0]               op_q, op_d;
  logic                     quo_q, quo_d;
  logic [39:0]              pre_q, pre_d;
  logic [2:0]               len_q, len_d;
  logic [POSITION_BITS-1:0] ln_q, ln_d, cl_q, cl_d;

  function automatic logic [15:0] sat(input logic [POSITION_BITS-1:0] v);
    if (POSITION_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic stok_pkg::rec_t mk(input logic kind, input logic [5:0] cls,
                                        input logic [7:0] ch,
                                        input logic [POSITION_BITS-1:0] ln,
                                        input logic [POSITION_BITS-1:0] cl);
    stok_pkg::rec_t r;
    r.kind = kind;
    r.cls  = cls;
    r.ch   = ch;
    r.line = sat(ln);
    r.col  = sat(cl);
    return r;
  endfunction

  always_comb begin
    logic [1:0] n;
    logic       done;
    logic [3:0] nxt;
    logic       nxt_ok;
    logic [7:0] d;
    logic [7:0] b;
    logic [5:0] c;
    mode_d = mode_q;
    op_d   = op_q;
    quo_d  = quo_q;
    pre_d  = pre_q;
    len_d  = len_q;
    ln_d   = ln_q;
    cl_d   = cl_q;
    bundle_o = '0;
    n = 2'd0;
    done = 1'b0;
    nxt = ModeIdle;
    nxt_ok = 1'b0;
    d = 8'd0;
    b = byte_i;
    c = stok_pkg::ClsError;

    if (eoi_i || b == 8'd0) begin
      c = stok_pkg::ClsEof;
      nxt_ok = 1'b1;
      case (mode_q)
        ModeIdent: c = stok_pkg::ident_class(pre_q, len_q);
        ModeAtom0: c = stok_pkg::ClsError;
        ModeAtom: c = stok_pkg::ClsAtom;
        ModeOp: c = stok_pkg::op_single(op_q);
        ModeInt, ModeDots, ModeFrac, ModeExpd: c = stok_pkg::ClsNumber;
        ModeExp, ModeSign: c = stok_pkg::ClsError;
        default: nxt_ok = 1'b0;
      endcase
      if (nxt_ok) begin
        bundle_o.rec[n] = mk(stok_pkg::KindEnd, c, 8'd0, ln_d, cl_d);
        n = n + 2'd1;
      end
      bundle_o.rec[n] = mk(stok_pkg::KindEnd, stok_pkg::ClsEof, 8'd0, ln_d, cl_d);
      n = n + 2'd1;
      mode_d = ModeIdle;
      done = 1'b1;
    end else begin
      case (mode_q)
        ModeIdle: ;
        ModeComment: begin
          if (b == 8'h0D || b == 8'h0A) mode_d = ModeIdle;
          else done = 1'b1;
        end
        ModeIdent: begin
          if (stok_pkg::is_name(b)) begin
            done = 1'b1;
            if (len_q < 3'd5) begin
              pre_d = {pre_q[31:0], b};
              len_d = len_q + 3'd1;
            end else begin
              len_d = 3'd6;
            end
          end else begin
            bundle_o.rec[n] = mk(stok_pkg::KindEnd, stok_pkg::ident_class(pre_q, len_q),
                                 8'd0, ln_d, cl_d);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
        ModeAtom0, ModeAtom: begin
          if (stok_pkg::is_name(b)) begin
            done = 1'b1;
            mode_d = ModeAtom;
          end else begin
            bundle_o.rec[n] = mk(stok_pkg::KindEnd, (mode_q == ModeAtom) ?
                                 stok_pkg::ClsAtom : stok_pkg::ClsError, 8'd0, ln_d, cl_d);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
        ModeStr, ModeEsc: done = 1'b1;
        ModeOp: begin
          if (b == stok_pkg::op_second(op_q)) done = 1'b1;
          else if (stok_pkg::is_sign(op_q) && stok_pkg::is_digit(b)) done = 1'b1;
          else begin
            bundle_o.rec[n] = mk(stok_pkg::KindEnd, stok_pkg::op_single(op_q), 8'd0,
                                 ln_d, cl_d);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
        ModeInt, ModeDots, ModeFrac, ModeExp, ModeSign, ModeExpd: begin
          if (stok_pkg::is_digit(b)) begin
            nxt_ok = 1'b1;
            nxt = (mode_q == ModeInt) ? ModeInt :
                  (mode_q == ModeDots || mode_q == ModeFrac) ? ModeFrac : ModeExpd;
          end else if (b == 8'h2E && (mode_q == ModeInt || mode_q == ModeDots)) begin
            nxt_ok = 1'b1;
            nxt = ModeDots;
          end else if (stok_pkg::is_e(b) && (mode_q == ModeInt || mode_q == ModeDots ||
                       mode_q == ModeFrac || mode_q == ModeExp)) begin
            nxt_ok = 1'b1;
            nxt = ModeExp;
          end else if (stok_pkg::is_sign(b) && (mode_q == ModeExp || mode_q == ModeSign)) begin
            nxt_ok = 1'b1;
            nxt = ModeSign;
          end
          if (nxt_ok) begin
            done = 1'b1;
          end else begin
            bundle_o.rec[n] = mk(stok_pkg::KindEnd, (mode_q == ModeExp || mode_q == ModeSign)
                                 ? stok_pkg::ClsError : stok_pkg::ClsNumber, 8'd0, ln_d, cl_d);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
        default: mode_d = ModeIdle;
      endcase

      // Every byte consumed moves the position, whoever consumes it.
      if (b == 8'h0A) begin
        if (ln_d < PosMax) ln_d = ln_d + PosOne;
        cl_d = PosOne;
      end else if (cl_d < PosMax) begin
        cl_d = cl_d + PosOne;
      end

      if (done) begin
        case (mode_q)
          ModeIdent, ModeAtom0, ModeAtom: begin
            bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
            n = n + 2'd1;
          end
          ModeStr: begin
            if (b == (quo_q ? 8'h27 : 8'h22)) begin
              bundle_o.rec[n] = mk(stok_pkg::KindEnd, stok_pkg::ClsString, 8'd0, ln_d, cl_d);
              n = n + 2'd1;
              mode_d = ModeIdle;
            end else if (b == 8'h5C) begin
              mode_d = ModeEsc;
            end else begin
              bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
              n = n + 2'd1;
            end
          end
          ModeEsc: begin
            mode_d = ModeStr;
            case (b)
              8'h61: d = 8'd7;
              8'h62: d = 8'd8;
              8'h66: d = 8'd12;
              8'h6E: d = 8'd10;
              8'h72: d = 8'd13;
              8'h74: d = 8'd9;
              8'h5C, 8'h27, 8'h22: d = b;
              default: d = 8'd0;
            endcase
            // Unknown escapes leave no content.
            if (d != 8'd0) begin
              bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, d, ln_d, cl_d);
              n = n + 2'd1;
            end
          end
          ModeOp: begin
            bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
            n = n + 2'd1;
            if (b == stok_pkg::op_second(op_q)) begin
              bundle_o.rec[n] = mk(stok_pkg::KindEnd, stok_pkg::op_double(op_q), 8'd0,
                                   ln_d, cl_d);
              n = n + 2'd1;
              mode_d = ModeIdle;
            end else begin
              mode_d = ModeInt;
            end
          end
          ModeInt, ModeDots, ModeFrac, ModeExp, ModeSign, ModeExpd: begin
            bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
            n = n + 2'd1;
            mode_d = nxt;
          end
          default: ;
        endcase
      end else begin
        // The byte starts afresh between tokens.
        c = stok_pkg::single_char(b);
        if (stok_pkg::is_space(b)) begin
          mode_d = ModeIdle;
        end else if (b == 8'h23) begin
          mode_d = ModeComment;
        end else if (stok_pkg::is_ident_start(b)) begin
          bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
          n = n + 2'd1;
          pre_d = {32'd0, b};
          len_d = 3'd1;
          mode_d = ModeIdent;
        end else if (stok_pkg::is_digit(b)) begin
          bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
          n = n + 2'd1;
          mode_d = ModeInt;
        end else if (b == 8'h3A) begin
          mode_d = ModeAtom0;
        end else if (b == 8'h22 || b == 8'h27) begin
          quo_d = (b == 8'h27);
          mode_d = ModeStr;
        end else begin
          bundle_o.rec[n] = mk(stok_pkg::KindContent, 6'd0, b, ln_d, cl_d);
          n = n + 2'd1;
          if (c != stok_pkg::ClsError) begin
            bundle_o.rec[n] = mk(stok_pkg::KindEnd, c, 8'd0, ln_d, cl_d);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end else if (stok_pkg::op_single(b) != stok_pkg::ClsError) begin
            op_d = b;
            mode_d = ModeOp;
          end else begin
            bundle_o.rec[n] = mk(stok_pkg::KindEnd, stok_pkg::ClsError, 8'd0, ln_d, cl_d);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end
        end
      end
    end
    bundle_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      op_q   <= 8'd0;
      quo_q  <= 1'b0;
      pre_q  <= 40'd0;
      len_q  <= 3'd0;
      ln_q   <= PosOne;
      cl_q   <= PosOne;
    end else if (accept_i) begin
      mode_q <= mode_d;
      op_q   <= op_d;
      quo_q  <= quo_d;
      pre_q  <= pre_d;
      len_q  <= len_d;
      ln_q   <= ln_d;
      cl_q   <= cl_d;
    end
  end

endmodule
`default_nettype wire

### hdl/stok_queue.sv
`default_nettype none
module stok_queue #(
  parameter int unsigned DEPTH = stok_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire stok_pkg::bundle_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output stok_pkg::bundle_t      data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  stok_pkg::bundle_t mem_q [DEPTH];
  logic [AW-1:0]     wr_q, rd_q;
  logic [AW:0]       cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i) rd_q <= inc(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

endmodule
`default_nettype wire

### hdl/stok_back.sv
`default_nettype none
module stok_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire stok_pkg::bundle_t head_i,
  output logic                   pop_o,
  stok_out_if.source             out_o
);

  logic [1:0]     idx_q;
  logic           fin;
  stok_pkg::rec_t r;

  assign r   = head_i.rec[idx_q];
  assign fin = idx_q == head_i.cnt - 2'd1;

  assign out_o.valid         = !empty_i;
  assign out_o.record_kind   = r.kind;
  assign out_o.token_class   = r.cls;
  assign out_o.char_value    = r.ch;
  assign out_o.line_number   = r.line;
  assign out_o.column_number = r.col;
  assign out_o.last          = fin;

  assign pop_o = out_o.valid && out_o.ready && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (out_o.valid && out_o.ready) begin
      idx_q <= fin ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule
`default_nettype wire

### hdl/source_tokenizer.sv
`default_nettype none
// Source tokenizer: takes one source byte per cycle while the queue is not full and
// emits content and token-end words with line and column. Each byte is scanned
// combinationally; its one to three words are queued as one entry, and a byte making
// no words is not queued. Output hands out one word per cycle while out_o.ready is
// high. Input stalls only when all QUEUE_DEPTH entries (one per byte) are full.
module source_tokenizer #(
  parameter int unsigned POSITION_BITS = stok_pkg::PositionBitsDefault,
  parameter int unsigned QUEUE_DEPTH   = stok_pkg::QueueDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stok_in_if.sink     in_i,
  stok_out_if.source  out_o
);

  stok_pkg::bundle_t bundle, head;
  logic              full, empty, pop, accept;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  stok_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_i.byte_in),
    .eoi_i    (in_i.end_of_input),
    .bundle_o (bundle)
  );

  stok_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && bundle.cnt != 2'd0),
    .data_i  (bundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head)
  );

  stok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
